>>> design/i2cms_pkg.sv
package i2cms_pkg;

    // Depth of the byte queue and of the tag queue
    localparam int QUEUE_DEPTH = 16;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Depth of the command queue between front and back
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_IDX_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_STATUS = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_START     = 3'd1,
        ACT_SEND      = 3'd2,
        ACT_RESTART   = 3'd3,
        ACT_STOP      = 3'd4,
        ACT_RECV_NACK = 3'd5
    } action_t;

    // Command classes handed from front to back
    typedef enum logic [2:0] {
        K_NONE        = 3'd0,
        K_WRITE       = 3'd1,
        K_READ        = 3'd2,
        K_ST_START    = 3'd3,
        K_ST_NEXT     = 3'd4,
        K_ST_DATA     = 3'd5,
        K_ST_ADDR_ACK = 3'd6,
        K_ST_NACK     = 3'd7
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  dev_address;
        logic [7:0]  reg_index;
        logic [7:0]  write_data;
        logic [7:0]  read_tag;
        logic [7:0]  read_byte;
    } cmd_t;

    typedef struct packed {
        action_t     bus_action;
        logic [7:0]  send_byte;
        logic        read_valid;
        logic [7:0]  read_dest_tag;
        logic [7:0]  read_value;
        logic        overflow;
    } result_t;

endpackage

>>> design/i2c_master_transaction_sequencer_unit.sv
// A command taken from the front queue passes the exec and emit states before its result
// is registered; a write or read also passes WR1 and WR2 for the three byte-queue writes.
// A new transaction is taken only after the last result is registered (held by a stalled
// output); an address NACK drops queued bytes one per exec/skip pass (one RAM read each).
// Reset: asynchronous, active low; clears queue pointers, counts and the busy flag,
// sets the address threshold to 0xE0. Queue RAM contents are not cleared.
module i2c_master_transaction_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] dev_address, [15:8] reg_index, [23:16] write_data,
    // [31:24] read_tag, [39:32] bus_status, [47:40] bus_read_byte
    input  logic [47:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] send_byte, [15:8] read_dest_tag, [23:16] read_value
    output logic [23:0] m_axis_tdata,
    // [2:0] bus_action, [3] read_valid, [4] overflow
    output logic [4:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic                cmd_valid;
    logic                cmd_pop;
    i2cms_pkg::cmd_t     cmd;
    i2cms_pkg::result_t  result;

    // Accept and classify transactions
    i2cms_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .in_opcode        (s_axis_tuser),
        .in_dev_address   (s_axis_tdata[7:0]),
        .in_reg_index     (s_axis_tdata[15:8]),
        .in_write_data    (s_axis_tdata[23:16]),
        .in_read_tag      (s_axis_tdata[31:24]),
        .in_bus_status    (s_axis_tdata[39:32]),
        .in_bus_read_byte (s_axis_tdata[47:40]),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_pop          (cmd_pop)
    );

    // Carry out commands against the byte and tag queues
    i2cms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_result  (result)
    );

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {result.read_value, result.read_dest_tag, result.send_byte};
    assign m_axis_tuser = {result.overflow, result.read_valid, result.bus_action};

endmodule

>>> design/i2cms_ram.sv
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/i2cms_front.sv
module i2cms_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_opcode,
    input  logic [7:0]         in_dev_address,
    input  logic [7:0]         in_reg_index,
    input  logic [7:0]         in_write_data,
    input  logic [7:0]         in_read_tag,
    input  logic [7:0]         in_bus_status,
    input  logic [7:0]         in_bus_read_byte,
    output logic               cmd_valid,
    output i2cms_pkg::cmd_t    cmd,
    input  logic               cmd_pop
);

    localparam logic [7:0] STATUS_MASK    = 8'hF8;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
    localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    function automatic i2cms_pkg::cmd_kind_t classify(input logic [1:0] op,
                                                      input logic [7:0] status);
        i2cms_pkg::cmd_kind_t k;
        k = i2cms_pkg::K_NONE;
        unique case (i2cms_pkg::opcode_t'(op))
            i2cms_pkg::OP_WRITE:  k = i2cms_pkg::K_WRITE;
            i2cms_pkg::OP_READ:   k = i2cms_pkg::K_READ;
            i2cms_pkg::OP_NOP:    k = i2cms_pkg::K_NONE;
            i2cms_pkg::OP_STATUS:
            begin
                unique case (status & STATUS_MASK)
                    ST_START, ST_RESTART:                     k = i2cms_pkg::K_ST_START;
                    ST_ADDR_W_ACK, ST_DATA_W_ACK, ST_DATA_W_NACK:
                                                              k = i2cms_pkg::K_ST_NEXT;
                    ST_DATA_R_ACK, ST_DATA_R_NACK:            k = i2cms_pkg::K_ST_DATA;
                    ST_ADDR_R_ACK:                            k = i2cms_pkg::K_ST_ADDR_ACK;
                    ST_ADDR_R_NACK, ST_ADDR_W_NACK:           k = i2cms_pkg::K_ST_NACK;
                    default:                                  k = i2cms_pkg::K_NONE;
                endcase
            end
            default: k = i2cms_pkg::K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [i2cms_pkg::CMDQ_IDX_W-1:0] ptr_inc(
        input logic [i2cms_pkg::CMDQ_IDX_W-1:0] p);
        if (p == i2cms_pkg::CMDQ_IDX_W'(i2cms_pkg::CMDQ_DEPTH - 1))
        begin
            return '0;
        end
        return p + i2cms_pkg::CMDQ_IDX_W'(1);
    endfunction

    i2cms_pkg::cmd_t                     entry_reg [i2cms_pkg::CMDQ_DEPTH];
    logic [i2cms_pkg::CMDQ_IDX_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [i2cms_pkg::CMDQ_IDX_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [i2cms_pkg::CMDQ_CNT_W-1:0]    count_reg, count_next;
    logic                                push, pop;
    i2cms_pkg::cmd_t                     new_cmd;

    // Classify the incoming transaction
    always_comb
    begin
        new_cmd.kind        = classify(in_opcode, in_bus_status);
        new_cmd.dev_address = in_dev_address;
        new_cmd.reg_index   = in_reg_index;
        new_cmd.write_data  = in_write_data;
        new_cmd.read_tag    = in_read_tag;
        new_cmd.read_byte   = in_bus_read_byte;
    end

    assign in_ready  = (count_reg != i2cms_pkg::CMDQ_CNT_W'(i2cms_pkg::CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;

    // Advance the queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + i2cms_pkg::CMDQ_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - i2cms_pkg::CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> design/i2cms_back.sv
module i2cms_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  i2cms_pkg::cmd_t     cmd,
    output logic                cmd_pop,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cms_pkg::result_t  m_result
);

    localparam logic [7:0] THRESHOLD_RESET = 8'hE0;
    localparam int IW = i2cms_pkg::Q_IDX_W;
    localparam int CW = i2cms_pkg::Q_CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WR1,
        S_WR2,
        S_SKIP,
        S_EMIT
    } state_t;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        if (idx == IW'(i2cms_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return idx + IW'(1);
    endfunction

    state_t              state_reg, state_next;
    i2cms_pkg::cmd_t     cmd_reg, cmd_next;
    i2cms_pkg::result_t  res_reg, res_next;
    i2cms_pkg::result_t  m_result_reg, m_result_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          thr_reg, thr_next;
    logic [IW-1:0]       byte_head_reg, byte_head_next;
    logic [IW-1:0]       byte_tail_reg, byte_tail_next;
    logic [CW-1:0]       byte_count_reg, byte_count_next;
    logic [IW-1:0]       tag_head_reg, tag_head_next;
    logic [IW-1:0]       tag_tail_reg, tag_tail_next;
    logic [CW-1:0]       tag_count_reg, tag_count_next;
    logic                busy_reg, busy_next;

    logic                byte_we;
    logic [7:0]          byte_wdata;
    logic [7:0]          byte_rdata;
    logic                tag_we;
    logic [7:0]          tag_rdata;
    logic                byte_full, tag_full, is_read;

    i2cms_ram #(.WIDTH(8), .DEPTH(i2cms_pkg::QUEUE_DEPTH)) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_we),
        .wr_addr (byte_tail_reg),
        .wr_data (byte_wdata),
        .rd_addr (byte_head_reg),
        .rd_data (byte_rdata)
    );

    i2cms_ram #(.WIDTH(8), .DEPTH(i2cms_pkg::QUEUE_DEPTH)) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_we),
        .wr_addr (tag_tail_reg),
        .wr_data (cmd_reg.read_tag),
        .rd_addr (tag_head_reg),
        .rd_data (tag_rdata)
    );

    assign byte_full = (byte_count_reg > CW'(i2cms_pkg::QUEUE_DEPTH - 3));
    assign tag_full  = (tag_count_reg == CW'(i2cms_pkg::QUEUE_DEPTH));
    assign is_read   = (cmd_reg.kind == i2cms_pkg::K_READ);
    assign m_valid   = m_valid_reg;
    assign m_result  = m_result_reg;

    // Sequence one command: queue bytes or pick the next bus action
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        m_result_next   = m_result_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        thr_next        = cfg_valid ? cfg_data : thr_reg;
        byte_head_next  = byte_head_reg;
        byte_tail_next  = byte_tail_reg;
        byte_count_next = byte_count_reg;
        tag_head_next   = tag_head_reg;
        tag_tail_next   = tag_tail_reg;
        tag_count_next  = tag_count_reg;
        busy_next       = busy_reg;
        byte_we         = 1'b0;
        byte_wdata      = cmd_reg.dev_address;
        tag_we          = 1'b0;
        cmd_pop         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    res_next   = '0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_EMIT;
                unique case (cmd_reg.kind)
                    i2cms_pkg::K_WRITE, i2cms_pkg::K_READ:
                    begin
                        if (byte_full || (is_read && tag_full))
                        begin
                            res_next.overflow = 1'b1;
                        end
                        else
                        begin
                            byte_we         = 1'b1;
                            byte_wdata      = is_read ? (cmd_reg.dev_address - 8'd1)
                                                      : cmd_reg.dev_address;
                            byte_tail_next  = idx_inc(byte_tail_reg);
                            byte_count_next = byte_count_reg + CW'(1);
                            state_next      = S_WR1;
                        end
                    end

                    i2cms_pkg::K_ST_START:
                    begin
                        if (byte_count_reg == '0)
                        begin
                            res_next.bus_action = i2cms_pkg::ACT_STOP;
                            busy_next           = 1'b0;
                        end
                        else
                        begin
                            res_next.bus_action = i2cms_pkg::ACT_SEND;
                            res_next.send_byte  = byte_rdata;
                            byte_head_next      = idx_inc(byte_head_reg);
                            byte_count_next     = byte_count_reg - CW'(1);
                        end
                    end

                    i2cms_pkg::K_ST_NEXT, i2cms_pkg::K_ST_DATA:
                    begin
                        // Deliver the received byte with its tag
                        if (cmd_reg.kind == i2cms_pkg::K_ST_DATA && tag_count_reg != '0)
                        begin
                            res_next.read_valid    = 1'b1;
                            res_next.read_dest_tag = tag_rdata;
                            res_next.read_value    = cmd_reg.read_byte;
                            tag_head_next          = idx_inc(tag_head_reg);
                            tag_count_next         = tag_count_reg - CW'(1);
                        end
                        // Continue the frame, restart, or stop
                        if (byte_count_reg == '0)
                        begin
                            res_next.bus_action = i2cms_pkg::ACT_STOP;
                            busy_next           = 1'b0;
                        end
                        else if (byte_rdata >= thr_reg)
                        begin
                            res_next.bus_action = i2cms_pkg::ACT_RESTART;
                        end
                        else
                        begin
                            res_next.bus_action = i2cms_pkg::ACT_SEND;
                            res_next.send_byte  = byte_rdata;
                            byte_head_next      = idx_inc(byte_head_reg);
                            byte_count_next     = byte_count_reg - CW'(1);
                        end
                    end

                    i2cms_pkg::K_ST_ADDR_ACK:
                    begin
                        res_next.bus_action = i2cms_pkg::ACT_RECV_NACK;
                    end

                    i2cms_pkg::K_ST_NACK:
                    begin
                        // Drop the rest of the frame one byte per pass
                        if (byte_count_reg != '0 && byte_rdata < thr_reg)
                        begin
                            byte_head_next  = idx_inc(byte_head_reg);
                            byte_count_next = byte_count_reg - CW'(1);
                            state_next      = S_SKIP;
                        end
                        else if (byte_count_reg != '0)
                        begin
                            res_next.bus_action = i2cms_pkg::ACT_RESTART;
                        end
                        else
                        begin
                            res_next.bus_action = i2cms_pkg::ACT_STOP;
                            busy_next           = 1'b0;
                        end
                    end

                    default:
                    begin
                        res_next.bus_action = i2cms_pkg::ACT_NONE;
                    end
                endcase
            end

            S_WR1:
            begin
                byte_we         = 1'b1;
                byte_wdata      = cmd_reg.reg_index;
                byte_tail_next  = idx_inc(byte_tail_reg);
                byte_count_next = byte_count_reg + CW'(1);
                state_next      = S_WR2;
            end

            S_WR2:
            begin
                byte_we         = 1'b1;
                byte_wdata      = is_read ? cmd_reg.dev_address : cmd_reg.write_data;
                byte_tail_next  = idx_inc(byte_tail_reg);
                byte_count_next = byte_count_reg + CW'(1);
                if (is_read)
                begin
                    tag_we         = 1'b1;
                    tag_tail_next  = idx_inc(tag_tail_reg);
                    tag_count_next = tag_count_reg + CW'(1);
                end
                // Issue a start only from idle
                if (!busy_reg)
                begin
                    res_next.bus_action = i2cms_pkg::ACT_START;
                    busy_next           = 1'b1;
                end
                state_next = S_EMIT;
            end

            S_SKIP:
            begin
                // Wait for the new head byte to be read
                state_next = S_EXEC;
            end

            S_EMIT:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    m_valid_next  = 1'b1;
                    m_result_next = res_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            thr_reg        <= THRESHOLD_RESET;
            byte_head_reg  <= '0;
            byte_tail_reg  <= '0;
            byte_count_reg <= '0;
            tag_head_reg   <= '0;
            tag_tail_reg   <= '0;
            tag_count_reg  <= '0;
            busy_reg       <= 1'b0;
            cmd_reg        <= '0;
            res_reg        <= '0;
            m_result_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            thr_reg        <= thr_next;
            byte_head_reg  <= byte_head_next;
            byte_tail_reg  <= byte_tail_next;
            byte_count_reg <= byte_count_next;
            tag_head_reg   <= tag_head_next;
            tag_tail_reg   <= tag_tail_next;
            tag_count_reg  <= tag_count_next;
            busy_reg       <= busy_next;
            cmd_reg        <= cmd_next;
            res_reg        <= res_next;
            m_result_reg   <= m_result_next;
        end
    end

    a_byte_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CW'(i2cms_pkg::QUEUE_DEPTH))
        else $error("byte queue count beyond depth");

    a_tag_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tag_count_reg <= CW'(i2cms_pkg::QUEUE_DEPTH))
        else $error("tag queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg == '0 |-> byte_head_reg == byte_tail_reg)
        else $error("empty byte queue with head and tail apart");

    a_overflow_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_result_reg.overflow) |->
        (m_result_reg.bus_action == i2cms_pkg::ACT_NONE && !m_result_reg.read_valid))
        else $error("dropped transaction came with a bus action");

    a_emit_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result presented outside the emit step");

endmodule
